### rtl/core/rcpc_pkg.sv
// ----------------------------------------------------------------------------
// rcpc_pkg
// shared types and constants of the convex polygon ray clip block
// ----------------------------------------------------------------------------
package rcpc_pkg;

  // item kinds after classification in the front part
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_DROP,
    KIND_CAST
  } kind_t;

  // configuration register indexes
  localparam logic [2:0] REG_EDGE_COUNT = 3'd0;
  localparam logic [2:0] REG_OFFSET_X   = 3'd1;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd2;
  localparam logic [2:0] REG_ROT_COS    = 3'd3;
  localparam logic [2:0] REG_ROT_SIN    = 3'd4;

  localparam logic [3:0]         RESET_EDGE_COUNT = 4'd4;
  localparam logic signed [15:0] RESET_ROT_COS    = 16'sd16384;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 24;

  // saturated quotient, 2^24
  localparam logic [24:0] FRAC_SAT = 25'h100_0000;

  typedef struct packed {
    logic [3:0]         edge_count;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [15:0] rot_cos;
    logic signed [15:0] rot_sin;
  } cfg_t;

  // queued item: load payload and ray already shifted by the frame offset
  typedef struct packed {
    kind_t              kind;
    logic [2:0]         slot;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [32:0] ax1;
    logic signed [32:0] ay1;
    logic signed [32:0] ax2;
    logic signed [32:0] ay2;
    logic [23:0]        maxf;
  } item_t;

endpackage

### rtl/core/rcpc_front.sv
// ----------------------------------------------------------------------------
// rcpc_front
// takes items and register writes, classifies items and offsets the ray
// ----------------------------------------------------------------------------
module rcpc_front #(
  parameter int MAX_EDGES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 q_full,
  input  logic                 op,
  input  logic [2:0]           edge_index,
  input  logic signed [31:0]   vertex_x,
  input  logic signed [31:0]   vertex_y,
  input  logic signed [15:0]   normal_x,
  input  logic signed [15:0]   normal_y,
  input  logic signed [31:0]   ray_start_x,
  input  logic signed [31:0]   ray_start_y,
  input  logic signed [31:0]   ray_end_x,
  input  logic signed [31:0]   ray_end_y,
  input  logic [23:0]          max_fraction,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 push,
  output rcpc_pkg::item_t      push_item,
  output rcpc_pkg::cfg_t       cfg
);

  assign push = start && !q_full;

  always_comb begin
    if (op == 1'b1) begin
      push_item.kind = rcpc_pkg::KIND_CAST;
    end else if (32'(edge_index) < 32'(MAX_EDGES)) begin
      push_item.kind = rcpc_pkg::KIND_LOAD;
    end else begin
      push_item.kind = rcpc_pkg::KIND_DROP;
    end
    push_item.slot = edge_index;
    push_item.vx   = vertex_x;
    push_item.vy   = vertex_y;
    push_item.nx   = normal_x;
    push_item.ny   = normal_y;
    push_item.ax1  = 33'(ray_start_x) - 33'(cfg.offset_x);
    push_item.ay1  = 33'(ray_start_y) - 33'(cfg.offset_y);
    push_item.ax2  = 33'(ray_end_x) - 33'(cfg.offset_x);
    push_item.ay2  = 33'(ray_end_y) - 33'(cfg.offset_y);
    push_item.maxf = max_fraction;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_count <= rcpc_pkg::RESET_EDGE_COUNT;
      cfg.offset_x   <= '0;
      cfg.offset_y   <= '0;
      cfg.rot_cos    <= rcpc_pkg::RESET_ROT_COS;
      cfg.rot_sin    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rcpc_pkg::REG_EDGE_COUNT: cfg.edge_count <= cfg_data[3:0];
        rcpc_pkg::REG_OFFSET_X:   cfg.offset_x   <= cfg_data;
        rcpc_pkg::REG_OFFSET_Y:   cfg.offset_y   <= cfg_data;
        rcpc_pkg::REG_ROT_COS:    cfg.rot_cos    <= cfg_data[15:0];
        rcpc_pkg::REG_ROT_SIN:    cfg.rot_sin    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/rcpc_queue.sv
// ----------------------------------------------------------------------------
// rcpc_queue
// short item queue between front and back
// ----------------------------------------------------------------------------
module rcpc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rcpc_pkg::item_t push_item,
  input  logic            pop,
  output rcpc_pkg::item_t head,
  output logic            full,
  output logic            empty
);

  localparam int PW = $clog2(rcpc_pkg::QUEUE_DEPTH);

  rcpc_pkg::item_t   mem [rcpc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;

  assign full  = (count == (PW+1)'(rcpc_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/rcpc_back.sv
// ----------------------------------------------------------------------------
// rcpc_back
// edge tables, shared multiplier, serial divider and clip sequencer
// ----------------------------------------------------------------------------
module rcpc_back #(
  parameter int MAX_EDGES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rcpc_pkg::cfg_t       cfg,
  input  rcpc_pkg::item_t      head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 done,
  output logic                 hit,
  output logic [23:0]          fraction,
  output logic signed [15:0]   hit_normal_x,
  output logic signed [15:0]   hit_normal_y
);

  localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_XF, ST_EDGE, ST_DEC, ST_PRE, ST_DIV, ST_UPD, ST_NORM, ST_DONE
  } state_t;

  state_t state;

  logic signed [31:0] vtab_x [MAX_EDGES];
  logic signed [31:0] vtab_y [MAX_EDGES];
  logic signed [15:0] ntab_x [MAX_EDGES];
  logic signed [15:0] ntab_y [MAX_EDGES];

  rcpc_pkg::item_t    item;
  logic [3:0]         step;
  logic [CW-1:0]      idx;
  logic [IW-1:0]      entry;
  logic               entry_ok;
  logic               miss;
  logic               entering;
  logic [24:0]        lower;
  logic [24:0]        upper;
  logic [24:0]        qres;
  logic signed [53:0] prod;
  logic signed [53:0] acc;
  logic signed [35:0] p1x;
  logic signed [35:0] p1y;
  logic signed [36:0] dx;
  logic signed [36:0] dy;
  logic signed [54:0] num;
  logic signed [54:0] den;
  logic [53:0]        amag;
  logic [53:0]        bmag;
  logic [53:0]        rem;
  logic [23:0]        sh;
  logic [23:0]        quo;
  logic [4:0]         dcnt;
  logic signed [15:0] wx;

  // combinational helpers
  logic [IW-1:0]      rd_idx;
  logic signed [31:0] rd_vx, rd_vy;
  logic signed [15:0] rd_nx, rd_ny;
  logic signed [16:0] mul_a;
  logic signed [36:0] mul_b;
  logic signed [16:0] c17, s17, ns17;
  logic signed [54:0] pair_sum;
  logic signed [40:0] pair_shr;
  logic signed [15:0] pair_sat;
  logic [4:0]         ec_wide;
  logic [CW-1:0]      n_use;
  logic [54:0]        rem2;
  logic               rem_ge;
  logic [23:0]        quo_next;
  logic [24:0]        lower_n, upper_n;
  logic               last_edge;

  assign rd_idx = (state == ST_NORM) ? entry : idx[IW-1:0];
  assign rd_vx  = vtab_x[rd_idx];
  assign rd_vy  = vtab_y[rd_idx];
  assign rd_nx  = ntab_x[rd_idx];
  assign rd_ny  = ntab_y[rd_idx];

  assign c17  = 17'(cfg.rot_cos);
  assign s17  = 17'(cfg.rot_sin);
  assign ns17 = -s17;

  assign ec_wide   = {1'b0, cfg.edge_count};
  assign n_use     = (ec_wide > 5'(MAX_EDGES)) ? CW'(MAX_EDGES) : CW'(ec_wide);
  assign last_edge = !(CW'(idx + 1'b1) < n_use);

  assign pair_sum = 55'(acc) + 55'(prod);
  assign pair_shr = 41'(pair_sum >>> 14);
  always_comb begin
    if (pair_shr > 41'sd32767) begin
      pair_sat = 16'sh7fff;
    end else if (pair_shr < -41'sd32768) begin
      pair_sat = -16'sh8000;
    end else begin
      pair_sat = pair_shr[15:0];
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = c17;
    mul_b = '0;
    case (state)
      ST_XF: begin
        case (step)
          4'd0: begin mul_a = c17;  mul_b = 37'(item.ax1); end
          4'd1: begin mul_a = s17;  mul_b = 37'(item.ay1); end
          4'd2: begin mul_a = c17;  mul_b = 37'(item.ay1); end
          4'd3: begin mul_a = ns17; mul_b = 37'(item.ax1); end
          4'd4: begin mul_a = c17;  mul_b = 37'(item.ax2); end
          4'd5: begin mul_a = s17;  mul_b = 37'(item.ay2); end
          4'd6: begin mul_a = c17;  mul_b = 37'(item.ay2); end
          4'd7: begin mul_a = ns17; mul_b = 37'(item.ax2); end
          default: ;
        endcase
      end
      ST_EDGE: begin
        case (step)
          4'd0: begin mul_a = 17'(rd_nx); mul_b = 37'(rd_vx) - 37'(p1x); end
          4'd1: begin mul_a = 17'(rd_ny); mul_b = 37'(rd_vy) - 37'(p1y); end
          4'd2: begin mul_a = 17'(rd_nx); mul_b = dx; end
          4'd3: begin mul_a = 17'(rd_ny); mul_b = dy; end
          default: ;
        endcase
      end
      ST_NORM: begin
        case (step)
          4'd0: begin mul_a = c17;  mul_b = 37'(rd_nx); end
          4'd1: begin mul_a = ns17; mul_b = 37'(rd_ny); end
          4'd2: begin mul_a = s17;  mul_b = 37'(rd_nx); end
          4'd3: begin mul_a = c17;  mul_b = 37'(rd_ny); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // one restoring division step
  assign rem2     = {rem, sh[23]};
  assign rem_ge   = (rem2 >= {1'b0, bmag});
  assign quo_next = {quo[22:0], rem_ge};

  always_comb begin
    lower_n = lower;
    upper_n = upper;
    if (entering) begin
      if (qres > lower) begin
        lower_n = qres;
      end
    end else if (qres < upper) begin
      upper_n = qres;
    end
  end

  assign pop = (state == ST_IDLE) && !empty;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (state == ST_IDLE && !empty && head.kind == rcpc_pkg::KIND_LOAD) begin
      vtab_x[IW'(head.slot)] <= head.vx;
      vtab_y[IW'(head.slot)] <= head.vy;
      ntab_x[IW'(head.slot)] <= head.nx;
      ntab_y[IW'(head.slot)] <= head.ny;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      hit          <= 1'b0;
      fraction     <= '0;
      hit_normal_x <= '0;
      hit_normal_y <= '0;
      entry_ok     <= 1'b0;
      miss         <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            item     <= head;
            step     <= '0;
            idx      <= '0;
            lower    <= '0;
            upper    <= {1'b0, head.maxf};
            miss     <= 1'b0;
            entry_ok <= 1'b0;
            state    <= (head.kind == rcpc_pkg::KIND_CAST) ? ST_XF : ST_DONE;
          end
        end
        ST_XF: begin
          if (step != 4'd0) begin
            if (step[0]) begin
              acc <= prod;
            end else begin
              unique case (step)
                4'd2: p1x <= pair_shr[35:0];
                4'd4: p1y <= pair_shr[35:0];
                4'd6: dx  <= 37'(pair_shr) - 37'(p1x);
                default: dy <= 37'(pair_shr) - 37'(p1y);
              endcase
            end
          end
          if (step == 4'd8) begin
            step  <= '0;
            state <= (n_use == '0) ? ST_DONE : ST_EDGE;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_EDGE: begin
          if (step != 4'd0) begin
            if (step[0]) begin
              acc <= prod;
            end else if (step == 4'd2) begin
              num <= pair_sum;
            end else begin
              den <= pair_sum;
            end
          end
          if (step == 4'd4) begin
            step  <= '0;
            state <= ST_DEC;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DEC: begin
          amag     <= num[54] ? 54'(-num) : num[53:0];
          bmag     <= den[54] ? 54'(-den) : den[53:0];
          entering <= den[54];
          if (den == '0) begin
            if (num[54]) begin
              miss  <= 1'b1;
              state <= ST_DONE;
            end else if (last_edge) begin
              state <= entry_ok ? ST_NORM : ST_DONE;
            end else begin
              idx   <= CW'(idx + 1'b1);
              state <= ST_EDGE;
            end
          end else if (den[54]) begin
            if (num[54]) begin
              state <= ST_PRE;
            end else if (last_edge) begin
              state <= entry_ok ? ST_NORM : ST_DONE;
            end else begin
              idx   <= CW'(idx + 1'b1);
              state <= ST_EDGE;
            end
          end else if (num[54]) begin
            miss  <= 1'b1;
            state <= ST_DONE;
          end else begin
            state <= ST_PRE;
          end
        end
        ST_PRE: begin
          // quotient of 256 or more saturates
          if ({8'd0, amag} >= {bmag, 8'd0}) begin
            qres  <= rcpc_pkg::FRAC_SAT;
            state <= ST_UPD;
          end else begin
            rem   <= {8'd0, amag[53:8]};
            sh    <= {amag[7:0], 16'd0};
            quo   <= '0;
            dcnt  <= 5'(rcpc_pkg::DIV_STEPS);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= rem_ge ? 54'(rem2 - {1'b0, bmag}) : rem2[53:0];
          sh   <= {sh[22:0], 1'b0};
          quo  <= quo_next;
          dcnt <= dcnt - 1'b1;
          if (dcnt == 5'd1) begin
            qres  <= {1'b0, quo_next};
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          lower <= lower_n;
          upper <= upper_n;
          if (entering && qres > lower) begin
            entry    <= idx[IW-1:0];
            entry_ok <= 1'b1;
          end
          if (upper_n < lower_n) begin
            miss  <= 1'b1;
            state <= ST_DONE;
          end else if (last_edge) begin
            state <= (entry_ok || (entering && qres > lower)) ? ST_NORM : ST_DONE;
          end else begin
            idx   <= CW'(idx + 1'b1);
            state <= ST_EDGE;
          end
        end
        ST_NORM: begin
          step <= step + 1'b1;
          if (step != 4'd0) begin
            if (step[0]) begin
              acc <= prod;
            end else if (step == 4'd2) begin
              wx <= pair_sat;
            end else begin
              hit_normal_x <= wx;
              hit_normal_y <= pair_sat;
            end
          end
          if (step == 4'd4) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (item.kind == rcpc_pkg::KIND_CAST && entry_ok && !miss) begin
            hit      <= 1'b1;
            fraction <= lower[23:0];
          end else begin
            hit          <= 1'b0;
            fraction     <= '0;
            hit_normal_x <= '0;
            hit_normal_y <= '0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/ray_convex_polygon_clip.sv
// ----------------------------------------------------------------------------
// ray_convex_polygon_clip
// segment ray clip against a stored convex polygon, fixed point
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  item in   start, busy            op, edge_index, vertex, normal, ray, max_fraction
//  result    done (one cycle)       hit, fraction, hit_normal_x, hit_normal_y
//  config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
//  a load gives its result without any edge work; a cast walks the edges, runs
//  the 24-step divider for each edge needing a quotient (not when it saturates)
//  and computes the normal on a hit, all through one shared multiplier.
//  reset is synchronous and clears control and configuration; edge tables hold
//  until loaded. a two-entry queue takes items while a cast runs; busy is high
//  when it is full. results cannot be held off by the receiver
module ray_convex_polygon_clip #(
  parameter int MAX_EDGES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op,
  input  logic [2:0]           edge_index,
  input  logic signed [31:0]   vertex_x,
  input  logic signed [31:0]   vertex_y,
  input  logic signed [15:0]   normal_x,
  input  logic signed [15:0]   normal_y,
  input  logic signed [31:0]   ray_start_x,
  input  logic signed [31:0]   ray_start_y,
  input  logic signed [31:0]   ray_end_x,
  input  logic signed [31:0]   ray_end_y,
  input  logic [23:0]          max_fraction,
  output logic                 done,
  output logic                 hit,
  output logic [23:0]          fraction,
  output logic signed [15:0]   hit_normal_x,
  output logic signed [15:0]   hit_normal_y,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  rcpc_pkg::cfg_t  cfg;
  rcpc_pkg::item_t push_item;
  rcpc_pkg::item_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  assign busy      = q_full;
  assign cfg_ready = 1'b1;

  rcpc_front #(.MAX_EDGES(MAX_EDGES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .q_full       (q_full),
    .op           (op),
    .edge_index   (edge_index),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .ray_start_x  (ray_start_x),
    .ray_start_y  (ray_start_y),
    .ray_end_x    (ray_end_x),
    .ray_end_y    (ray_end_y),
    .max_fraction (max_fraction),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .push_item    (push_item),
    .cfg          (cfg)
  );

  rcpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  rcpc_back #(.MAX_EDGES(MAX_EDGES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .done         (done),
    .hit          (hit),
    .fraction     (fraction),
    .hit_normal_x (hit_normal_x),
    .hit_normal_y (hit_normal_y)
  );

endmodule
